FILE: src/mm_pkg.sv
// shared types and constants of the matrix multiply core
package mm_pkg;

    localparam int unsigned MM_MAX_DIM   = 8;
    localparam int unsigned MM_FRAC_BITS = 16;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned CIDX_W = 2;

    localparam logic [1:0] OP_WR_LEFT  = 2'd0;
    localparam logic [1:0] OP_WR_RIGHT = 2'd1;
    localparam logic [1:0] OP_COMPUTE  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_B_COLS    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_mm_in_item;

    typedef struct packed {
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic signed [DATA_W-1:0] product;
        logic                     saturated;
        logic                     last;
    } t_mm_out_item;

    typedef struct packed {
        logic             rd_en;
        logic             first_k;
        logic             last_k;
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
        logic [POS_W-1:0] k;
        logic             elem_last;
    } t_mm_cmd;

    typedef struct packed {
        logic moved;
    } t_mm_stat;

endpackage

FILE: src/mm_ram.sv
// generic simple dual port ram with registered read
module mm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mm_ctrl.sv
// controller: configuration registers and element / inner index sequencer
module mm_ctrl import mm_pkg::*; #(
    parameter int unsigned MAX_DIM = MM_MAX_DIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_start,
    output logic              o_busy,
    output t_mm_cmd           o_cmd,
    input  t_mm_stat          i_stat
);

    localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_mm_state;

    t_mm_state        r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CFG_W-1:0] r_a_rows, r_inner_dim, r_b_cols;
    logic [IDX_W-1:0] w_lim_m, w_lim_n, w_lim_p;
    logic             w_elem_last;

    function automatic logic [IDX_W-1:0] f_lim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] lim;
        if (v == '0) begin
            lim = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            lim = CFG_W'(MAX_DIM - 1);
        end else begin
            lim = v - 1'b1;
        end
        return IDX_W'(lim);
    endfunction

    assign w_lim_m = f_lim(r_a_rows);
    assign w_lim_n = f_lim(r_inner_dim);
    assign w_lim_p = f_lim(r_b_cols);
    assign w_elem_last = (r_i == w_lim_m) && (r_j == w_lim_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= CFG_RESET;
            r_inner_dim <= CFG_RESET;
            r_b_cols    <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A_ROWS:    r_a_rows    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_B_COLS:    r_b_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_k == w_lim_n) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_stat.moved) begin
                    if (w_elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = '0;
                        n_state = S_RUN;
                        if (r_j == w_lim_p) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_cmd.rd_en     = (r_state == S_RUN);
    assign o_cmd.first_k   = (r_k == '0);
    assign o_cmd.last_k    = (r_k == w_lim_n);
    assign o_cmd.i         = POS_W'(r_i);
    assign o_cmd.j         = POS_W'(r_j);
    assign o_cmd.k         = POS_W'(r_k);
    assign o_cmd.elem_last = w_elem_last;

    a_move_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.moved |-> r_state == S_WAIT)
        else $error("result moved while not waiting");

    a_index_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && !i_stat.moved) |=> $stable(r_i) && $stable(r_j))
        else $error("element index changed before its result was moved");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_k <= w_lim_n)
        else $error("inner index beyond dimension");

    a_end_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && i_stat.moved && w_elem_last) |=> r_state == S_IDLE)
        else $error("sequencer kept running after final element");

endmodule

FILE: src/mm_datapath.sv
// datapath: element stores, multiply, accumulate, truncate and saturate, output register
module mm_datapath import mm_pkg::*; #(
    parameter int unsigned MAX_DIM   = MM_MAX_DIM,
    parameter int unsigned FRAC_BITS = MM_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_accept,
    input  t_mm_in_item  i_in_item,
    input  t_mm_cmd      i_cmd,
    output t_mm_stat     o_stat,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_mm_out_item o_out_item
);

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PROD_W = 2 * DATA_W;
    localparam int unsigned ACC_W = PROD_W + $clog2(MAX_DIM) + 1;

    logic                     w_in_range, w_we_left, w_we_right;
    logic [AW-1:0]            w_waddr, w_raddr_left, w_raddr_right;
    logic [DATA_W-1:0]        w_rdata_left, w_rdata_right;
    logic                     r_s1_valid, r_s1_first, r_s1_last;
    logic                     r_s2_valid, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_rdy;
    logic signed [ACC_W-1:0]  w_shift;
    logic                     w_fits, w_move;
    logic                     r_out_valid;
    t_mm_out_item             r_out_item;

    // load path
    assign w_in_range = ({1'b0, i_in_item.row} < (POS_W + 1)'(MAX_DIM))
                     && ({1'b0, i_in_item.col} < (POS_W + 1)'(MAX_DIM));
    assign w_we_left  = i_in_accept && w_in_range && (i_in_item.opcode == OP_WR_LEFT);
    assign w_we_right = i_in_accept && w_in_range && (i_in_item.opcode == OP_WR_RIGHT);
    assign w_waddr    = AW'(i_in_item.row) * AW'(MAX_DIM) + AW'(i_in_item.col);

    assign w_raddr_left  = AW'(i_cmd.i) * AW'(MAX_DIM) + AW'(i_cmd.k);
    assign w_raddr_right = AW'(i_cmd.k) * AW'(MAX_DIM) + AW'(i_cmd.j);

    mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_we_left),
        .i_waddr (w_waddr),
        .i_wdata (i_in_item.value),
        .i_raddr (w_raddr_left),
        .o_rdata (w_rdata_left)
    );

    mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_we_right),
        .i_waddr (w_waddr),
        .i_wdata (i_in_item.value),
        .i_raddr (w_raddr_right),
        .o_rdata (w_rdata_right)
    );

    // multiply and accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_rdata_left) * $signed(w_rdata_right);
        if (r_s2_valid) begin
            if (r_s2_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc_rdy  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid && r_s2_last) begin
                r_acc_rdy <= 1'b1;
            end else if (w_move) begin
                r_acc_rdy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first_k;
        r_s1_last  <= i_cmd.last_k;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
    end

    // truncate toward minus infinity, then clip
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_fits  = (&w_shift[ACC_W-1:DATA_W-1]) || !(|w_shift[ACC_W-1:DATA_W-1]);
    assign w_move  = r_acc_rdy && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_item.out_row   <= i_cmd.i;
            r_out_item.out_col   <= i_cmd.j;
            r_out_item.saturated <= !w_fits;
            r_out_item.last      <= i_cmd.elem_last;
            if (w_fits) begin
                r_out_item.product <= w_shift[DATA_W-1:0];
            end else if (r_acc[ACC_W-1]) begin
                r_out_item.product <= Q_MIN;
            end else begin
                r_out_item.product <= Q_MAX;
            end
        end
    end

    assign o_stat.moved = w_move;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out_item;

endmodule

FILE: src/matrix_multiply_core.sv
// top level of the matrix multiply core
//
// input channel: items with opcode write-left, write-right or compute; an item
// is taken when i_in_valid is high and o_in_stall is low. element writes are
// taken one per cycle while o_in_stall is low; writes whose row or col is outside
// the store are dropped, and an unused opcode is dropped.
// a compute item raises o_in_stall until the last product element has entered
// the output register. it yields a_rows * b_cols items in row-major order, the
// final one with last set. each element takes inner_dim reads of the two stores
// (one port each), then passes the ram read, multiply and accumulate stages.
// output channel: o_out_valid with o_out_item; a stalled item holds, and the
// sequencer waits until the output register is free.
// configuration: i_cfg_valid / o_cfg_ready, register index and 4 bit data,
// written only while idle; o_cfg_ready is low while a compute item runs.
// reset sets all dimensions to 8 and empties the pipeline; the element stores
// keep whatever they held.
module matrix_multiply_core import mm_pkg::*; #(
    parameter int unsigned MAX_DIM   = MM_MAX_DIM,
    parameter int unsigned FRAC_BITS = MM_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_mm_in_item       i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_mm_out_item      o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic     w_busy, w_in_accept, w_start;
    t_mm_cmd  w_cmd;
    t_mm_stat w_stat;

    assign o_in_stall  = w_busy;
    assign o_cfg_ready = !w_busy;
    assign w_in_accept = i_in_valid && !w_busy;
    assign w_start     = w_in_accept && (i_in_item.opcode == OP_COMPUTE);

    mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (w_start),
        .o_busy      (w_busy),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mm_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/matrix_multiply_core_tb.sv
// self-checking testbench of the matrix multiply core with a class scoreboard
`timescale 1ns / 1ps

module matrix_multiply_core_tb;
    import mm_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         TOTAL_ITEMS  = 430;
    localparam int         QUIET_FROM   = 370;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         STORE_DEPTH  = MM_MAX_DIM * MM_MAX_DIM;

    class matmul_scoreboard;
        logic signed [DATA_W-1:0] left_mat  [STORE_DEPTH];
        logic signed [DATA_W-1:0] right_mat [STORE_DEPTH];
        logic [CFG_W-1:0]         a_rows;
        logic [CFG_W-1:0]         inner_dim;
        logic [CFG_W-1:0]         b_cols;
        t_mm_out_item             expected_products [$];
        int                       errors;
        int                       checked;
        int                       sat_seen;

        function new();
            foreach (left_mat[e]) begin
                left_mat[e]  = '0;
                right_mat[e] = '0;
            end
            a_rows    = CFG_RESET;
            inner_dim = CFG_RESET;
            b_cols    = CFG_RESET;
            errors    = 0;
            checked   = 0;
            sat_seen  = 0;
        endfunction

        function int eff(logic [CFG_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > MM_MAX_DIM) begin
                return MM_MAX_DIM;
            end
            return int'(v);
        endfunction

        function void set_dim(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_A_ROWS: begin
                    a_rows = v;
                end
                CFG_INNER_DIM: begin
                    inner_dim = v;
                end
                CFG_B_COLS: begin
                    b_cols = v;
                end
                default: begin
                end
            endcase
        endfunction

        // wide exact sum, floor shift, then clip
        function t_mm_out_item product_element(int i, int j, int n);
            t_mm_out_item             e;
            logic signed [71:0]       acc;
            logic signed [71:0]       shifted;
            logic signed [63:0]       prod;
            acc = '0;
            for (int k = 0; k < n; k++) begin
                prod = left_mat[i * MM_MAX_DIM + k] * right_mat[k * MM_MAX_DIM + j];
                acc  = acc + prod;
            end
            shifted = acc >>> MM_FRAC_BITS;
            e = '0;
            e.out_row = POS_W'(i);
            e.out_col = POS_W'(j);
            if (shifted > Q_MAX) begin
                e.product   = Q_MAX;
                e.saturated = 1'b1;
            end else if (shifted < Q_MIN) begin
                e.product   = Q_MIN;
                e.saturated = 1'b1;
            end else begin
                e.product   = shifted[DATA_W-1:0];
                e.saturated = 1'b0;
            end
            return e;
        endfunction

        function void note_input(t_mm_in_item it);
            t_mm_out_item e;
            int           m;
            int           n;
            int           p;
            case (it.opcode)
                OP_WR_LEFT: begin
                    left_mat[it.row * MM_MAX_DIM + it.col] = it.value;
                end
                OP_WR_RIGHT: begin
                    right_mat[it.row * MM_MAX_DIM + it.col] = it.value;
                end
                OP_COMPUTE: begin
                    m = eff(a_rows);
                    n = eff(inner_dim);
                    p = eff(b_cols);
                    for (int i = 0; i < m; i++) begin
                        for (int j = 0; j < p; j++) begin
                            e = product_element(i, j, n);
                            e.last = (i == m - 1) && (j == p - 1);
                            expected_products.push_back(e);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_mm_out_item got);
            t_mm_out_item want;
            if (expected_products.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %h", $time, got);
                return;
            end
            want = expected_products.pop_front();
            checked++;
            if (got.saturated === 1'b1) begin
                sat_seen++;
            end
            compare_field("out_row", want.out_row, got.out_row);
            compare_field("out_col", want.out_col, got.out_col);
            compare_field("product", want.product, got.product);
            compare_field("saturated", want.saturated, got.saturated);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_products.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_mm_in_item       i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    t_mm_out_item      o_out_item;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    matmul_scoreboard board = new();
    bit               gaps_on = 1'b1;
    int               items_sent = 0;
    int               dim_settings = 0;
    bit               left_set  [STORE_DEPTH];
    bit               right_set [STORE_DEPTH];

    matrix_multiply_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 15))
            0: begin
                v = Q_MAX;
            end
            1: begin
                v = Q_MIN;
            end
            2: begin
                v = '0;
            end
            3: begin
                v = $urandom();
            end
            4: begin
                v = -1;
            end
            default: begin
                v = $urandom_range(0, 32'h3FFFF);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] rand_dim();
        logic [CFG_W-1:0] d;
        case ($urandom_range(0, 15))
            0: begin
                d = '0;
            end
            1: begin
                d = 4'd15;
            end
            2: begin
                d = 4'd8;
            end
            3: begin
                d = CFG_W'($urandom_range(9, 14));
            end
            default: begin
                d = CFG_W'($urandom_range(1, 4));
            end
        endcase
        return d;
    endfunction

    task automatic send_item(input t_mm_in_item it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(it);
        if (it.opcode != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic load(input logic [1:0] op, input int r, input int c,
                        input logic signed [DATA_W-1:0] v);
        t_mm_in_item it;
        it.opcode = op;
        it.row    = POS_W'(r);
        it.col    = POS_W'(c);
        it.value  = v;
        send_item(it);
        if (op == OP_WR_LEFT) begin
            left_set[r * MM_MAX_DIM + c] = 1'b1;
        end else begin
            right_set[r * MM_MAX_DIM + c] = 1'b1;
        end
    endtask

    task automatic send_op(input logic [1:0] op);
        t_mm_in_item it;
        it.opcode = op;
        it.row    = POS_W'($urandom());
        it.col    = POS_W'($urandom());
        it.value  = $urandom();
        send_item(it);
    endtask

    task automatic fill_needed(input int m, input int n, input int p);
        for (int i = 0; i < m; i++) begin
            for (int k = 0; k < n; k++) begin
                if (!left_set[i * MM_MAX_DIM + k]) begin
                    load(OP_WR_LEFT, i, k, rand_value());
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < p; j++) begin
                if (!right_set[k * MM_MAX_DIM + j]) begin
                    load(OP_WR_RIGHT, k, j, rand_value());
                end
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] nd,
                              input logic [CFG_W-1:0] bc);
        logic [CIDX_W-1:0] regs [3];
        logic [CFG_W-1:0]  vals [3];
        regs[0] = CFG_A_ROWS;
        regs[1] = CFG_INNER_DIM;
        regs[2] = CFG_B_COLS;
        vals[0] = ar;
        vals[1] = nd;
        vals[2] = bc;
        for (int r = 0; r < 3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            board.set_dim(regs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
        dim_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] nd,
                             input logic [CFG_W-1:0] bc, input int ncomp);
        int m;
        int n;
        int p;
        int nw;
        wait_drained();
        write_dims(ar, nd, bc);
        m = board.eff(ar);
        n = board.eff(nd);
        p = board.eff(bc);
        for (int c = 0; c < ncomp; c++) begin
            nw = $urandom_range(0, 6);
            for (int w = 0; w < nw; w++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_op(OP_UNUSED);
                end else begin
                    load(($urandom_range(0, 1) == 1) ? OP_WR_RIGHT : OP_WR_LEFT,
                         $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
                end
            end
            fill_needed(m, n, p);
            send_op(OP_COMPUTE);
        end
    endtask

    initial begin : out_side
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                board.check_result(o_out_item);
            end
            if (hold > 0) begin
                hold--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 18);
            end
            i_out_stall <= (hold > 0);
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_A_ROWS;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element: clipping both ways, exact top value, floor rounding
        write_dims(4'd1, 4'd1, 4'd1);
        load(OP_WR_LEFT, 0, 0, Q_MAX);
        load(OP_WR_RIGHT, 0, 0, Q_MAX);
        send_op(OP_COMPUTE);
        load(OP_WR_RIGHT, 0, 0, Q_MIN);
        send_op(OP_COMPUTE);
        load(OP_WR_LEFT, 0, 0, Q_MIN);
        send_op(OP_COMPUTE);
        load(OP_WR_LEFT, 0, 0, 32'sh0001_0000);
        load(OP_WR_RIGHT, 0, 0, Q_MAX);
        send_op(OP_COMPUTE);
        load(OP_WR_LEFT, 0, 0, 32'sd1);
        load(OP_WR_RIGHT, 0, 0, -32'sd1);
        send_op(OP_UNUSED);
        send_op(OP_COMPUTE);
        load(OP_WR_LEFT, 7, 7, Q_MIN);
        load(OP_WR_RIGHT, 7, 7, Q_MAX);
        load(OP_WR_RIGHT, 0, 0, 32'shFFFF_0000);
        // zero dimensions act as one
        wait_drained();
        write_dims(4'd0, 4'd0, 4'd0);
        send_op(OP_COMPUTE);
        // largest dimensions
        run_phase(4'd15, 4'd15, 4'd15, 1);

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= QUIET_FROM) begin
                gaps_on = 1'b0;
            end
            run_phase(rand_dim(), rand_dim(), rand_dim(), $urandom_range(1, 3));
        end

        wait_drained();
        $display("run covered %0d items over %0d dimension settings", items_sent,
                 dim_settings);
        $display("checked %0d product elements, %0d of them clipped", board.checked,
                 board.sat_seen);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
